FILE: design/dpq_pkg.sv
// Shared types, constants and helper functions for the double-ended priority queue.
// The node memory and the top-level controller both use it; it depends on nothing.
`default_nettype none

package dpq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int NODE_CNT  = CAPACITY / 2;
    localparam int NODE_AW   = 9;
    localparam int CNT_W     = 11;
    localparam int VAL_W     = 32;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [NODE_AW-1:0]      node_addr_t;
    typedef logic [CNT_W-1:0]        count_t;

    // One interval-heap node: hi is the largest and lo the smallest entry it holds.
    typedef struct packed {
        val_t hi;
        val_t lo;
    } node_t;

    typedef struct packed {
        logic       en;
        node_addr_t addr;
        node_t      data;
    } ram_wr_t;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_DEL_MAX = 2'd1;
    localparam logic [1:0] OP_DEL_MIN = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic SIDE_LO = 1'b0;
    localparam logic SIDE_HI = 1'b1;

    // Fills the free half of a node with v; a single-entry node holds v in both halves.
    function automatic node_t node_fill(val_t v, val_t other, logic single, logic side);
        node_t n;
        if (single) begin
            n.hi = v;
            n.lo = v;
        end else if (side == SIDE_LO) begin
            n.hi = other;
            n.lo = v;
        end else begin
            n.hi = v;
            n.lo = other;
        end
        return n;
    endfunction

    function automatic node_addr_t parent_of(node_addr_t idx);
        node_addr_t t;
        t = idx - node_addr_t'(1);
        return t >> 1;
    endfunction

endpackage

`default_nettype wire

FILE: design/dpq_node_ram.sv
// Node store of the interval heap: one write port and one read port, read data registered.
// Depends on dpq_pkg for the node and write-request types.
`default_nettype none

module dpq_node_ram (
    input  wire                  clk,
    input  dpq_pkg::ram_wr_t     wr,
    input  dpq_pkg::node_addr_t  rd_addr,
    output dpq_pkg::node_t       rd_data
);
    import dpq_pkg::*;

    node_t node_mem [NODE_CNT];
    node_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            node_mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= node_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/double_ended_priority_queue.sv
// Double-ended priority queue: the top-level controller, built as an interval heap
// over the node memory dpq_node_ram, and using the types of dpq_pkg.
// An insert moves up one heap level per step, a removal down one level per step with
// two child reads on the single read port, over at most nine levels. One request is in
// progress at a time; the next start is taken in the cycle the result is shown. Reset
// empties the queue at once.
`default_nettype none

module double_ended_priority_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire  [1:0]          opcode,
    input  wire  signed [31:0]  value,
    output logic                done,
    output logic [1:0]          status,
    output logic                is_empty,
    output logic signed [31:0]  max_value,
    output logic signed [31:0]  min_value,
    output logic [10:0]         entry_count
);
    import dpq_pkg::*;

    // Controller states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_RDL  = 4'd1;
    localparam logic [3:0] S_INS_CMP  = 4'd2;
    localparam logic [3:0] S_PLACE    = 4'd3;
    localparam logic [3:0] S_DEL2     = 4'd4;
    localparam logic [3:0] S_DEL_RDL  = 4'd5;
    localparam logic [3:0] S_DEL_ROOT = 4'd6;
    localparam logic [3:0] S_DEL_C1   = 4'd7;
    localparam logic [3:0] S_DEL_CMP  = 4'd8;
    localparam logic [3:0] S_RPT      = 4'd9;
    localparam logic [3:0] S_RES      = 4'd10;

    logic [3:0] state_reg, state_next;
    count_t     count_reg, count_next;
    logic [1:0] op_reg, op_next;
    logic [1:0] status_reg, status_next;

    // The node that holds the hole being moved, the entry that travels, and the
    // entry that shares the hole's node.
    node_addr_t k_reg, k_next;
    val_t       e_reg, e_next;
    val_t       other_reg, other_next;
    logic       single_reg, single_next;
    logic       side_reg, side_next;
    logic       first_reg, first_next;
    node_t      c1_reg, c1_next;
    logic       c2v_reg, c2v_next;

    logic        done_reg, done_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic        res_empty_reg, res_empty_next;
    val_t        res_max_reg, res_max_next;
    val_t        res_min_reg, res_min_next;
    count_t      res_count_reg, res_count_next;

    ram_wr_t    wr;
    node_addr_t rd_addr;
    node_t      rd_data;

    dpq_node_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Helper terms used by the state machine.
    count_t     cnt_m1;
    node_addr_t last_del;
    node_addr_t p_idx;
    logic       is_min;
    logic       ins_side;
    logic       ins_move;
    val_t       ins_w;
    logic [CNT_W-1:0] c1_w, c2_w, last_w;
    logic       c2_sel;
    node_t      cd;
    node_addr_t c_idx;
    logic       c_single;
    logic       del_move;
    logic [CNT_W-1:0] cc1_w;
    logic       ld_pair;
    val_t       del_y;
    val_t       del_rem;

    assign cnt_m1   = count_reg - count_t'(1);
    // Index of the last node once the removal has been counted.
    assign last_del = cnt_m1[NODE_AW:1];
    assign last_w   = {2'b00, last_del};
    assign p_idx    = parent_of(k_reg);
    assign is_min   = (op_reg == OP_DEL_MIN);

    // Insert: the first step from a lone new node picks its side; later steps keep it.
    assign ins_side = (first_reg && single_reg) ? ((e_reg < rd_data.lo) ? SIDE_LO : SIDE_HI)
                                                 : side_reg;
    assign ins_move = (ins_side == SIDE_LO) ? (e_reg < rd_data.lo) : (e_reg > rd_data.hi);
    assign ins_w    = (ins_side == SIDE_LO) ? rd_data.lo : rd_data.hi;

    // Removal: children of the current node and the one that leads on.
    assign c1_w     = {1'b0, k_reg, 1'b1};
    assign c2_w     = {1'b0, k_reg, 1'b0} + count_t'(2);
    assign c2_sel   = c2v_reg && (is_min ? (rd_data.lo < c1_reg.lo)
                                         : (rd_data.hi > c1_reg.hi));
    assign cd       = c2_sel ? rd_data : c1_reg;
    assign c_idx    = c2_sel ? c2_w[NODE_AW-1:0] : c1_w[NODE_AW-1:0];
    assign c_single = (c_idx == last_del) && count_reg[0];
    assign del_move = is_min ? (e_reg > cd.lo) : (e_reg < cd.hi);
    assign cc1_w    = {1'b0, c_idx, 1'b1};

    // The last node lost one entry; when it held two, the other one stays behind alone.
    assign ld_pair  = count_reg[0];
    assign del_y    = (!is_min && ld_pair) ? rd_data.hi : rd_data.lo;
    assign del_rem  = is_min ? rd_data.hi : rd_data.lo;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        k_next          = k_reg;
        e_next          = e_reg;
        other_next      = other_reg;
        single_next     = single_reg;
        side_next       = side_reg;
        first_next      = first_reg;
        c1_next         = c1_reg;
        c2v_next        = c2v_reg;
        done_next       = 1'b0;
        res_status_next = res_status_reg;
        res_empty_next  = res_empty_reg;
        res_max_next    = res_max_reg;
        res_min_next    = res_min_reg;
        res_count_next  = res_count_reg;
        wr              = '0;
        rd_addr         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = opcode;
                    e_next      = value;
                    status_next = ST_DONE;
                    unique case (opcode)
                        OP_INSERT:
                        begin
                            if (count_reg == count_t'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RPT;
                            end
                            else if (count_reg == '0)
                            begin
                                wr.en      = 1'b1;
                                wr.addr    = '0;
                                wr.data    = node_fill(value, value, 1'b1, SIDE_LO);
                                count_next = count_reg + count_t'(1);
                                state_next = S_RPT;
                            end
                            else
                            begin
                                k_next     = count_reg[NODE_AW:1];
                                count_next = count_reg + count_t'(1);
                                if (count_reg[0])
                                begin
                                    rd_addr    = count_reg[NODE_AW:1];
                                    state_next = S_INS_RDL;
                                end
                                else
                                begin
                                    single_next = 1'b1;
                                    first_next  = 1'b1;
                                    other_next  = value;
                                    rd_addr     = parent_of(count_reg[NODE_AW:1]);
                                    state_next  = S_INS_CMP;
                                end
                            end
                        end
                        OP_DEL_MAX, OP_DEL_MIN:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RPT;
                            end
                            else if (count_reg == count_t'(1))
                            begin
                                count_next = '0;
                                state_next = S_RPT;
                            end
                            else if (count_reg == count_t'(2))
                            begin
                                count_next = count_t'(1);
                                rd_addr    = '0;
                                state_next = S_DEL2;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                                rd_addr    = cnt_m1[NODE_AW:1];
                                state_next = S_DEL_RDL;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_RPT;
                        end
                        default:
                        begin
                            state_next = S_RPT;
                        end
                    endcase
                end
            end

            S_INS_RDL:
            begin
                // The last node held one entry; the new one pairs up with it.
                if (k_reg == '0)
                begin
                    wr.en      = 1'b1;
                    wr.addr    = '0;
                    wr.data.hi = (e_reg > rd_data.lo) ? e_reg : rd_data.lo;
                    wr.data.lo = (e_reg > rd_data.lo) ? rd_data.lo : e_reg;
                    state_next = S_RPT;
                end
                else
                begin
                    other_next  = rd_data.lo;
                    side_next   = (e_reg < rd_data.lo) ? SIDE_LO : SIDE_HI;
                    single_next = 1'b0;
                    first_next  = 1'b0;
                    rd_addr     = p_idx;
                    state_next  = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                wr.en   = 1'b1;
                wr.addr = k_reg;
                if (ins_move)
                begin
                    wr.data     = node_fill(ins_w, other_reg, single_reg, ins_side);
                    k_next      = p_idx;
                    other_next  = (ins_side == SIDE_LO) ? rd_data.hi : rd_data.lo;
                    single_next = 1'b0;
                    side_next   = ins_side;
                    first_next  = 1'b0;
                    if (p_idx == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_addr    = parent_of(p_idx);
                        state_next = S_INS_CMP;
                    end
                end
                else
                begin
                    wr.data    = node_fill(e_reg, other_reg, single_reg, ins_side);
                    state_next = S_RPT;
                end
            end

            S_PLACE:
            begin
                wr.en      = 1'b1;
                wr.addr    = k_reg;
                wr.data    = node_fill(e_reg, other_reg, single_reg, side_reg);
                state_next = S_RPT;
            end

            S_DEL2:
            begin
                wr.en      = 1'b1;
                wr.addr    = '0;
                wr.data    = node_fill(del_rem, del_rem, 1'b1, SIDE_LO);
                state_next = S_RPT;
            end

            S_DEL_RDL:
            begin
                e_next = del_y;
                if (ld_pair)
                begin
                    wr.en   = 1'b1;
                    wr.addr = count_reg[NODE_AW:1];
                    wr.data = node_fill(del_rem, del_rem, 1'b1, SIDE_LO);
                end
                rd_addr    = '0;
                state_next = S_DEL_ROOT;
            end

            S_DEL_ROOT:
            begin
                k_next      = '0;
                single_next = 1'b0;
                side_next   = is_min ? SIDE_LO : SIDE_HI;
                other_next  = is_min ? rd_data.hi : rd_data.lo;
                if (last_del != '0)
                begin
                    rd_addr    = node_addr_t'(1);
                    state_next = S_DEL_C1;
                end
                else
                begin
                    wr.en      = 1'b1;
                    wr.addr    = '0;
                    wr.data    = node_fill(e_reg, is_min ? rd_data.hi : rd_data.lo, 1'b0,
                                           is_min ? SIDE_LO : SIDE_HI);
                    state_next = S_RPT;
                end
            end

            S_DEL_C1:
            begin
                c1_next  = rd_data;
                c2v_next = (c2_w <= last_w);
                rd_addr  = c2_w[NODE_AW-1:0];
                state_next = S_DEL_CMP;
            end

            S_DEL_CMP:
            begin
                wr.en   = 1'b1;
                wr.addr = k_reg;
                if (del_move)
                begin
                    wr.data     = node_fill(is_min ? cd.lo : cd.hi, other_reg, single_reg,
                                            side_reg);
                    k_next      = c_idx;
                    single_next = c_single;
                    // Entering a two-entry node may need a swap to keep lo below hi.
                    if (is_min)
                    begin
                        if (!c_single && (e_reg > cd.hi))
                        begin
                            other_next = e_reg;
                            e_next     = cd.hi;
                        end
                        else
                        begin
                            other_next = cd.hi;
                        end
                    end
                    else
                    begin
                        if (!c_single && (e_reg < cd.lo))
                        begin
                            other_next = e_reg;
                            e_next     = cd.lo;
                        end
                        else
                        begin
                            other_next = cd.lo;
                        end
                    end
                    if (cc1_w <= last_w)
                    begin
                        rd_addr    = cc1_w[NODE_AW-1:0];
                        state_next = S_DEL_C1;
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    wr.data    = node_fill(e_reg, other_reg, single_reg, side_reg);
                    state_next = S_RPT;
                end
            end

            S_RPT:
            begin
                rd_addr    = '0;
                state_next = S_RES;
            end

            S_RES:
            begin
                done_next       = 1'b1;
                res_status_next = status_reg;
                res_count_next  = count_reg;
                res_empty_next  = (count_reg == '0);
                res_max_next    = (count_reg == '0) ? val_t'(0) : rd_data.hi;
                res_min_next    = (count_reg == '0) ? val_t'(0) : rd_data.lo;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        status_reg     <= status_next;
        k_reg          <= k_next;
        e_reg          <= e_next;
        other_reg      <= other_next;
        single_reg     <= single_next;
        side_reg       <= side_next;
        first_reg      <= first_next;
        c1_reg         <= c1_next;
        c2v_reg        <= c2v_next;
        res_status_reg <= res_status_next;
        res_empty_reg  <= res_empty_next;
        res_max_reg    <= res_max_next;
        res_min_reg    <= res_min_next;
        res_count_reg  <= res_count_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = res_status_reg;
    assign is_empty    = res_empty_reg;
    assign max_value   = res_max_reg;
    assign min_value   = res_min_reg;
    assign entry_count = res_count_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not occupy the controller");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a request is still in progress");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (entry_count <= 11'(CAPACITY)))
        else $error("entry count beyond capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !is_empty) |-> (max_value >= min_value))
        else $error("largest value below smallest value");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the double-ended priority queue.
// Drives insert, remove-max, remove-min and clear requests and checks every result
// against a behavioural multiset predictor. Depends on dpq_pkg and the design only.
`timescale 1ns / 100ps

module testbench;
    import dpq_pkg::*;

    localparam int CAP = 1024;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic [1:0]         opcode;
    logic signed [31:0] value;
    wire                busy;
    wire                done;
    wire  [1:0]         status;
    wire                is_empty;
    wire  signed [31:0] max_value;
    wire  signed [31:0] min_value;
    wire  [10:0]        entry_count;

    double_ended_priority_queue u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .value       (value),
        .done        (done),
        .status      (status),
        .is_empty    (is_empty),
        .max_value   (max_value),
        .min_value   (min_value),
        .entry_count (entry_count)
    );

    // One expected outcome of a request.
    typedef struct packed {
        logic [1:0]         st;
        logic               emp;
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        logic [10:0]        cnt;
    } outcome_t;

    // The predictor's view of the queue: only the multiset of live values matters,
    // since which slot a removal takes cannot be seen from outside.
    logic signed [31:0] held_vals[$];
    outcome_t           pending_outcomes[$];
    int                 fail_count = 0;

    // Directed stimulus. A row with known set carries its expected outcome, which is
    // checked against the predictor as well as the design.
    typedef struct {
        logic [1:0]         op;
        logic signed [31:0] val;
        logic               known;
        outcome_t           want;
    } stim_row_t;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one request to the predicted queue and returns the outcome.
    function automatic outcome_t apply_request(logic [1:0] op, logic signed [31:0] v);
        outcome_t o;
        int       pick;
        o.st = ST_DONE;
        case (op)
            OP_INSERT:
            begin
                if (held_vals.size() >= CAP)
                    o.st = ST_FULL;
                else
                    held_vals.insert(held_vals.size(), v);
            end
            OP_DEL_MAX, OP_DEL_MIN:
            begin
                if (held_vals.size() == 0)
                    o.st = ST_EMPTY;
                else
                begin
                    pick = 0;
                    for (int i = 1; i < held_vals.size(); i++)
                        if ((op == OP_DEL_MAX) ? (held_vals[i] > held_vals[pick])
                                               : (held_vals[i] < held_vals[pick]))
                            pick = i;
                    held_vals.delete(pick);
                end
            end
            default:
                held_vals.delete();
        endcase
        o.emp = (held_vals.size() == 0);
        o.hi  = 0;
        o.lo  = 0;
        if (held_vals.size() != 0)
        begin
            o.hi = held_vals[0];
            o.lo = held_vals[0];
            foreach (held_vals[i])
            begin
                if (held_vals[i] > o.hi) o.hi = held_vals[i];
                if (held_vals[i] < o.lo) o.lo = held_vals[i];
            end
        end
        o.cnt = 11'(held_vals.size());
        return o;
    endfunction

    // Checker: each strobe is one result transfer, compared with the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result st=%0d cnt=%0d", $realtime, status,
                         entry_count);
                fail_count++;
            end
            else
            begin
                e = pending_outcomes.pop_front();
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $realtime, e.st, status);
                    fail_count++;
                end
                if (is_empty !== e.emp)
                begin
                    $display("%0t: is_empty expected %0d actual %0d", $realtime, e.emp,
                             is_empty);
                    fail_count++;
                end
                if (max_value !== e.hi)
                begin
                    $display("%0t: max_value expected %0d actual %0d", $realtime, e.hi,
                             max_value);
                    fail_count++;
                end
                if (min_value !== e.lo)
                begin
                    $display("%0t: min_value expected %0d actual %0d", $realtime, e.lo,
                             min_value);
                    fail_count++;
                end
                if (entry_count !== e.cnt)
                begin
                    $display("%0t: entry_count expected %0d actual %0d", $realtime, e.cnt,
                             entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Burst/gap state of the sender.
    int burst_left = 0;

    // Presents one request and waits for its transfer. Between bursts the sender idles
    // for a random gap; start stays high from one transfer to the next inside a burst.
    task automatic send_request(logic [1:0] op, logic signed [31:0] v, outcome_t want,
                                logic known);
        outcome_t got;
        int       gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start  <= 1'b1;
        opcode <= op;
        value  <= v;
        got = apply_request(op, v);
        if (known && got !== want)
        begin
            $display("%0t: table row disagrees with prediction, expected %h actual %h",
                     $realtime, want, got);
            fail_count++;
        end
        pending_outcomes.insert(pending_outcomes.size(), got);
        @(posedge clk);
        while (busy) @(posedge clk);
        // The transfer happens at the edge just reached; start is lowered or changed by
        // the caller's next step, or by the idle code below.
    endtask

    task automatic go_idle();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Random value, weighted towards extremes and a narrow band so that ties occur.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000 + $urandom_range(0, 3);
            1:       return 32'sh7FFF_FFFF - $urandom_range(0, 3);
            2, 3:    return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(int n_items);
        int         sel;
        int         fill_mode;
        logic [1:0] op;
        fill_mode = 0;
        for (int k = 0; k < n_items; k++)
        begin
            // Phases: balanced traffic, or traffic drifting up or down, picked at random.
            if (k % 200 == 0) fill_mode = $urandom_range(0, 2);
            sel = $urandom_range(0, 99);
            if (sel < 2)
                op = OP_CLEAR;
            else if (sel < (fill_mode == 1 ? 75 : fill_mode == 2 ? 25 : 50))
                op = OP_INSERT;
            else
                op = ($urandom_range(0, 1) != 0) ? OP_DEL_MAX : OP_DEL_MIN;
            send_request(op, pick_value(), '0, 1'b0);
        end
    endtask

    initial
    begin
        stim_row_t rows[$];
        clk    = 1'b0;
        rst_n  = 1'b0;
        start  = 1'b0;
        opcode = OP_INSERT;
        value  = '0;

        // Removals and clear on an empty queue, then extremes and ties.
        rows.insert(rows.size(), '{OP_DEL_MAX, 0, 1, '{ST_EMPTY, 1, 0, 0, 0}});
        rows.insert(rows.size(), '{OP_DEL_MIN, 0, 1, '{ST_EMPTY, 1, 0, 0, 0}});
        rows.insert(rows.size(), '{OP_CLEAR, 0, 1, '{ST_DONE, 1, 0, 0, 0}});
        rows.insert(rows.size(), '{OP_INSERT, 32'sh7FFF_FFFF, 1,
                         '{ST_DONE, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1}});
        rows.insert(rows.size(), '{OP_INSERT, 32'sh8000_0000, 1,
                         '{ST_DONE, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 2}});
        rows.insert(rows.size(), '{OP_INSERT, -1, 0, '0});
        rows.insert(rows.size(), '{OP_INSERT, -1, 0, '0});
        rows.insert(rows.size(), '{OP_INSERT, 0, 0, '0});
        rows.insert(rows.size(), '{OP_DEL_MAX, 0, 0, '0});
        rows.insert(rows.size(), '{OP_DEL_MIN, 0, 0, '0});
        rows.insert(rows.size(), '{OP_DEL_MIN, 0, 0, '0});
        rows.insert(rows.size(), '{OP_DEL_MAX, 0, 0, '0});
        rows.insert(rows.size(), '{OP_DEL_MAX, 0, 1, '{ST_DONE, 1, 0, 0, 0}});
        rows.insert(rows.size(), '{OP_INSERT, 32'sh5555_AAAA, 0, '0});
        rows.insert(rows.size(), '{OP_INSERT, 32'shAAAA_5555, 0, '0});
        rows.insert(rows.size(), '{OP_CLEAR, 0, 1, '{ST_DONE, 1, 0, 0, 0}});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_request(rows[i].op, rows[i].val, rows[i].want, rows[i].known);

        run_random(250);

        // Hold off until every expected result has arrived.
        go_idle();
        while (pending_outcomes.size() != 0) @(posedge clk);

        // Fill to capacity, then push past it: the overflow rows report full.
        for (int k = 0; k < CAP + 4; k++)
            send_request(OP_INSERT, pick_value(), '0, 1'b0);
        run_random(150);
        send_request(OP_CLEAR, 0, '{ST_DONE, 1, 0, 0, 0}, 1'b1);
        run_random(250);

        go_idle();
        fork
            begin
                while (pending_outcomes.size() != 0) @(posedge clk);
            end
            begin
                repeat (5000) @(posedge clk);
            end
        join_any
        disable fork;
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_outcomes.size() == 0)
            $display("double_ended_priority_queue regression: pass");
        else
            $display("double_ended_priority_queue regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of about 1700 items.
    initial
    begin
        #20ms;
        $display("double_ended_priority_queue regression: fail");
        $finish;
    end

endmodule
